>>> sv/i8mm_pkg.sv
// shared constants and types for the int8 tile matrix engine
`default_nettype none

package i8mm_pkg;

   // tile geometry
   localparam int TILE_ROWS  = 64;
   localparam int TILE_COLS  = 8;
   localparam int REDUCE_LEN = 32;

   // field widths
   localparam int KIND_W = 2;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 3;
   localparam int K_W    = 5;
   localparam int BYTE_W = 8;
   localparam int ACC_W  = 32;

   // store geometry
   localparam int A_DEPTH  = TILE_ROWS * REDUCE_LEN;
   localparam int B_DEPTH  = TILE_COLS * REDUCE_LEN;
   localparam int A_ADDR_W = ROW_W + K_W;
   localparam int B_ADDR_W = COL_W + K_W;

   // datapath widths
   localparam int OPND_W = BYTE_W + 1;   // byte with sign or zero extension
   localparam int PROD_W = 2 * OPND_W;
   localparam int SUM_W  = 23;           // 32 terms of at most 255*255
   localparam int TOT_W  = ACC_W + 1;    // dot product plus accumulator

   localparam logic signed [ACC_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] RES_MIN = 32'sh8000_0000;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_LOAD_A  = 2'd0;
   localparam kind_type KIND_LOAD_B  = 2'd1;
   localparam kind_type KIND_COMPUTE = 2'd2;

   // register word indexes
   localparam logic REG_A_SIGNED = 1'b0;
   localparam logic REG_B_SIGNED = 1'b1;

endpackage

`default_nettype wire

>>> sv/int8_tile_matmul_saturating_unit.sv
// int8 tile matrix engine top level: stores, sequencer, shared multiply-accumulate
`default_nettype none

// Holds a 64x32 byte A tile and an 8x32 byte B tile in two rams. A load request
// (kind 0 or 1) writes one byte and gives no response. A compute request (kind 2)
// walks the 32 reduction positions of one A row and one B column through a single
// shared 9x9-bit multiplier and accumulator, one position per cycle, optionally adds
// the signed 32-bit acc_in and saturates to the signed 32-bit range.
// After acceptance the walk issues one read per position, limited by the one ram read
// port per store feeding the one multiplier; the ram read, multiply and accumulate
// pipeline then drains, and the final add and clamp produce the response.
// The block is not ready while a compute is running; a finished response sits in an
// output register, so loads and the next compute can be taken while it waits.
// Kind 3 is accepted and dropped. The stores are not cleared by reset: reading a byte
// that was never loaded gives an arbitrary value. The config registers a_signed (byte
// address 0) and b_signed (byte address 4) choose signed or unsigned byte interpretation;
// both reset to signed; the user must change them only while idle (not enforced here).

module int8_tile_matmul_saturating_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [i8mm_pkg::KIND_W-1:0]         req_kind,
   input  logic [i8mm_pkg::ROW_W-1:0]          req_row_index,
   input  logic [i8mm_pkg::COL_W-1:0]          req_col_index,
   input  logic [i8mm_pkg::K_W-1:0]            req_k_index,
   input  logic [i8mm_pkg::BYTE_W-1:0]         req_element_byte,
   input  logic signed [i8mm_pkg::ACC_W-1:0]   req_acc_in,
   input  logic                                req_include_acc,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [i8mm_pkg::ACC_W-1:0]   rsp_result_value,
   // config port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;  // taking requests
   localparam logic [1:0] ST_ISSUE  = 2'd1;  // one ram read per reduction position
   localparam logic [1:0] ST_DRAIN  = 2'd2;  // last products still in flight
   localparam logic [1:0] ST_FINISH = 2'd3;  // add accumulator, clamp, hand off

   logic [1:0] state_ff, state_in;

   // config registers
   logic a_signed_ff, a_signed_in;
   logic b_signed_ff, b_signed_in;
   logic csr_wr;

   // latched compute operands
   logic [i8mm_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [i8mm_pkg::COL_W-1:0]        col_ff, col_in;
   logic signed [i8mm_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                              inc_ff, inc_in;

   // reduction walk
   logic [i8mm_pkg::K_W-1:0] k_ff, k_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     prod_vld_ff, prod_vld_in;
   logic                     issue;

   // datapath
   logic [i8mm_pkg::BYTE_W-1:0]        a_rd_data, b_rd_data;
   logic signed [i8mm_pkg::OPND_W-1:0] a_opnd, b_opnd;
   logic signed [i8mm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [i8mm_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic signed [i8mm_pkg::TOT_W-1:0]  total;
   logic signed [i8mm_pkg::ACC_W-1:0]  clamped;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [i8mm_pkg::ACC_W-1:0] rsp_value_ff, rsp_value_in;

   // request decode
   logic req_fire;
   logic load_a, load_b, start;
   logic out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_a    = req_fire && (req_kind == i8mm_pkg::KIND_LOAD_A);
   assign load_b    = req_fire && (req_kind == i8mm_pkg::KIND_LOAD_B);
   assign start     = req_fire && (req_kind == i8mm_pkg::KIND_COMPUTE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = (state_ff == ST_ISSUE);

   // ---------------------------------------------------------------------------
   // config port: word index is paddr[2], only bit 0 of the data is kept
   // ---------------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      a_signed_in = a_signed_ff;
      b_signed_in = b_signed_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            i8mm_pkg::REG_A_SIGNED: a_signed_in = pwdata[0];
            i8mm_pkg::REG_B_SIGNED: b_signed_in = pwdata[0];
            default:                ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         i8mm_pkg::REG_A_SIGNED: prdata = {31'd0, a_signed_ff};
         i8mm_pkg::REG_B_SIGNED: prdata = {31'd0, b_signed_ff};
         default:                prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // tile stores: written by load requests, read by the reduction walk
   // ---------------------------------------------------------------------------
   i8mm_ram #(
      .WIDTH (i8mm_pkg::BYTE_W),
      .DEPTH (i8mm_pkg::A_DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr ({req_row_index, req_k_index}),
      .wr_data (req_element_byte),
      .rd_en   (issue),
      .rd_addr ({row_ff, k_ff}),
      .rd_data (a_rd_data)
   );

   i8mm_ram #(
      .WIDTH (i8mm_pkg::BYTE_W),
      .DEPTH (i8mm_pkg::B_DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr ({req_col_index, req_k_index}),
      .wr_data (req_element_byte),
      .rd_en   (issue),
      .rd_addr ({col_ff, k_ff}),
      .rd_data (b_rd_data)
   );

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      acc_in   = acc_ff;
      inc_in   = inc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ISSUE;
               k_in     = '0;
               row_in   = req_row_index;
               col_in   = req_col_index;
               acc_in   = req_acc_in;
               inc_in   = req_include_acc;
            end
         end
         ST_ISSUE: begin
            k_in = k_ff + 1'b1;
            if (k_ff == i8mm_pkg::K_W'(i8mm_pkg::REDUCE_LEN - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // sum is final once nothing is left in the read or multiply stage
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // shared multiply-accumulate: ram read -> product register -> accumulator
   // ---------------------------------------------------------------------------
   assign rd_vld_in   = issue;
   assign prod_vld_in = rd_vld_ff;

   // each byte widened to 9 bits, sign or zero extended per config
   assign a_opnd  = signed'({a_signed_ff & a_rd_data[i8mm_pkg::BYTE_W-1], a_rd_data});
   assign b_opnd  = signed'({b_signed_ff & b_rd_data[i8mm_pkg::BYTE_W-1], b_rd_data});
   assign prod_in = a_opnd * b_opnd;

   always_comb begin
      sum_in = sum_ff;
      if (start) begin
         sum_in = '0;
      end else if (prod_vld_ff) begin
         sum_in = sum_ff + i8mm_pkg::SUM_W'(prod_ff);
      end
   end

   // final add of the optional accumulator and clamp to signed 32 bits
   assign total = i8mm_pkg::TOT_W'(sum_ff)
                + (inc_ff ? i8mm_pkg::TOT_W'(acc_ff) : i8mm_pkg::TOT_W'(0));

   always_comb begin
      if (total > i8mm_pkg::TOT_W'(i8mm_pkg::RES_MAX)) begin
         clamped = i8mm_pkg::RES_MAX;
      end else if (total < i8mm_pkg::TOT_W'(i8mm_pkg::RES_MIN)) begin
         clamped = i8mm_pkg::RES_MIN;
      end else begin
         clamped = total[i8mm_pkg::ACC_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = clamped;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   // ---------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         a_signed_ff  <= 1'b1;
         b_signed_ff  <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         a_signed_ff  <= a_signed_in;
         b_signed_ff  <= b_signed_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      acc_ff       <= acc_in;
      inc_ff       <= inc_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      rsp_value_ff <= rsp_value_in;
   end

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------

   // a product is only ever formed from ram data read the cycle before
   a_prod_follows_read: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> $past(rd_vld_ff))
      else $error("product stage valid without a preceding ram read");

   // the clamp only sees a complete sum
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!rd_vld_ff && !prod_vld_ff))
      else $error("final add started with products still in flight");

   // a new response only comes out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   // no request is taken while the reduction walk owns the stores
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff || prod_vld_ff) |-> !req_ready)
      else $error("request accepted during a compute");

endmodule

`default_nettype wire

>>> sv/i8mm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module i8mm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
